FILE: rtl/tlrp_pkg.sv
package tlrp_pkg;

   localparam int MAP_DIM_DEF = 256;
   localparam int MAX_HW_DEF  = 15;
   localparam int FRAC_DEF    = 16;

   localparam int COORD_W = 11;
   localparam int DIFF_W  = 11;
   localparam int OFS_W   = 12;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [OFS_W-1:0]   wcoord_type;

   typedef struct packed {
      logic      go;
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
   } dda_cmd_type;

   typedef struct packed {
      logic      pt_valid;
      logic      done;
      coord_type px;
      coord_type py;
   } dda_stat_type;

endpackage

FILE: rtl/thick_line_road_plotter_unit.sv
// channel   | ports                                     | transfer
// ----------+-------------------------------------------+----------------------------
// request   | start, busy, req_cmd, req_* fields        | start && !busy at clock edge
// response  | rsp_valid, rsp_road_bit                   | one cycle strobe, no stall
//
// After reset the map is swept clear, one cell per cycle, over all MAP_DIM*MAP_DIM cells.
// For a read, the strobe comes the cycle after the transfer.
// Each line of a draw runs two divisions on the shared divider, then a DDA walk; a draw
// adds one clip scan when an endpoint is off the map, plus two squares of (2w+1)^2 cells.
// Lines drawn: 4w+1. Response side cannot stall; busy stays high until a draw completes.
module thick_line_road_plotter_unit import tlrp_pkg::*; #(
   parameter int MAP_DIM        = MAP_DIM_DEF,
   parameter int MAX_HALF_WIDTH = MAX_HW_DEF,
   parameter int FRAC_BITS      = FRAC_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_cmd,
   input  logic signed [10:0] req_start_x,
   input  logic signed [10:0] req_start_y,
   input  logic signed [10:0] req_end_x,
   input  logic signed [10:0] req_end_y,
   input  logic [3:0]       req_half_width,
   input  logic [7:0]       req_cell_x,
   input  logic [7:0]       req_cell_y,
   output logic             rsp_valid,
   output logic             rsp_road_bit
);

   localparam int DEPTH  = MAP_DIM * MAP_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int XW     = $clog2(MAP_DIM);
   localparam int WW     = $clog2(MAX_HALF_WIDTH + 2);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_CLIP   = 3'd3;
   localparam logic [2:0] ST_CHECK  = 3'd4;
   localparam logic [2:0] ST_SQUARE = 3'd5;
   localparam logic [2:0] ST_LSET   = 3'd6;
   localparam logic [2:0] ST_LINE   = 3'd7;

   typedef logic signed [WW:0] sq_type;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   coord_type         sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [WW-1:0]     w_ff, w_in;
   logic              clip_end_ff, clip_end_in, found_ff, found_in;
   sq_type            sqi_ff, sqi_in, sqj_ff, sqj_in;
   logic              sq_sel_ff, sq_sel_in;
   logic [WW-1:0]     ls_ff, ls_in;
   logic [1:0]        ldir_ff, ldir_in;
   logic              rd_ok_ff, rd_ok_in;

   dda_cmd_type       dcmd;
   dda_stat_type      dstat;
   logic              accept, s_on, e_on, pt_on, sq_on;
   logic [WW-1:0]     w_sat;
   sq_type            w_s;
   wcoord_type        sq_x, sq_y, ox, oy, soff, psx, psy, pex, pey;
   logic              we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic              ram_q;

   function automatic logic on_map(input wcoord_type c);
      return (c >= 0) && (c < MAP_DIM);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [XW-1:0] x,
                                                    input logic [XW-1:0] y);
      return ADDR_W'(ADDR_W'(x) * ADDR_W'(MAP_DIM) + ADDR_W'(y));
   endfunction

   tlrp_dda #(.FRAC_BITS(FRAC_BITS)) u_dda (
      .clock (clock),
      .reset (reset),
      .cmd   (dcmd),
      .stat  (dstat)
   );

   tlrp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (state_ff != ST_CLEAR),
      .raddr (raddr),
      .rdata (ram_q)
   );

   always_comb begin
      accept = start && (state_ff == ST_IDLE);
      w_sat  = (32'(req_half_width) > MAX_HALF_WIDTH) ? WW'(MAX_HALF_WIDTH)
                                                      : WW'(req_half_width);
      w_s    = sq_type'({1'b0, w_ff});
      s_on   = on_map(wcoord_type'(sx_ff)) && on_map(wcoord_type'(sy_ff));
      e_on   = on_map(wcoord_type'(ex_ff)) && on_map(wcoord_type'(ey_ff));
      pt_on  = on_map(wcoord_type'(dstat.px)) && on_map(wcoord_type'(dstat.py));
      sq_x   = (sq_sel_ff ? wcoord_type'(ex_ff) : wcoord_type'(sx_ff)) + wcoord_type'(sqi_ff);
      sq_y   = (sq_sel_ff ? wcoord_type'(ey_ff) : wcoord_type'(sy_ff)) + wcoord_type'(sqj_ff);
      sq_on  = on_map(sq_x) && on_map(sq_y);

      soff = wcoord_type'({1'b0, ls_ff});
      ox   = '0;
      oy   = '0;
      if (ls_ff != '0) begin
         case (ldir_ff)
            2'd0:    ox = -soff;
            2'd1:    oy = -soff;
            2'd2:    ox = soff;
            default: oy = soff;
         endcase
      end
      psx = wcoord_type'(sx_ff) + ox;
      psy = wcoord_type'(sy_ff) + oy;
      pex = wcoord_type'(ex_ff) + ox;
      pey = wcoord_type'(ey_ff) + oy;
      if (!(on_map(psx) && on_map(psy))) begin
         psx = wcoord_type'(sx_ff);
         psy = wcoord_type'(sy_ff);
      end
      if (!(on_map(pex) && on_map(pey))) begin
         pex = wcoord_type'(ex_ff);
         pey = wcoord_type'(ey_ff);
      end

      dcmd.go = 1'b0;
      dcmd.ax = COORD_W'(psx);
      dcmd.ay = COORD_W'(psy);
      dcmd.bx = COORD_W'(pex);
      dcmd.by = COORD_W'(pey);

      state_in    = state_ff;
      clr_in      = clr_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      ex_in       = ex_ff;
      ey_in       = ey_ff;
      w_in        = w_ff;
      clip_end_in = clip_end_ff;
      found_in    = found_ff;
      sqi_in      = sqi_ff;
      sqj_in      = sqj_ff;
      sq_sel_in   = sq_sel_ff;
      ls_in       = ls_ff;
      ldir_in     = ldir_ff;
      rd_ok_in    = rd_ok_ff;
      we          = 1'b0;
      waddr       = clr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            we     = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd) begin
                  rd_ok_in = (32'(req_cell_x) < MAP_DIM) && (32'(req_cell_y) < MAP_DIM);
                  state_in = ST_READ;
               end else begin
                  sx_in    = req_start_x;
                  sy_in    = req_start_y;
                  ex_in    = req_end_x;
                  ey_in    = req_end_y;
                  w_in     = w_sat;
                  found_in = 1'b0;
                  dcmd.ax  = req_start_x;
                  dcmd.ay  = req_start_y;
                  dcmd.bx  = req_end_x;
                  dcmd.by  = req_end_y;
                  if (!(on_map(wcoord_type'(req_start_x)) &&
                        on_map(wcoord_type'(req_start_y)))) begin
                     dcmd.go     = 1'b1;
                     clip_end_in = 1'b0;
                     state_in    = ST_CLIP;
                  end else if (!(on_map(wcoord_type'(req_end_x)) &&
                                 on_map(wcoord_type'(req_end_y)))) begin
                     dcmd.go     = 1'b1;
                     clip_end_in = 1'b1;
                     state_in    = ST_CLIP;
                  end else begin
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_CLIP: begin
            if (dstat.pt_valid && pt_on) begin
               if (clip_end_ff) begin
                  ex_in = dstat.px;
                  ey_in = dstat.py;
               end else if (!found_ff) begin
                  sx_in    = dstat.px;
                  sy_in    = dstat.py;
                  found_in = 1'b1;
               end
            end
            if (dstat.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (s_on && e_on) begin
               sqi_in    = -w_s;
               sqj_in    = -w_s;
               sq_sel_in = 1'b0;
               state_in  = ST_SQUARE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SQUARE: begin
            we    = sq_on;
            waddr = cell_addr(XW'(sq_x), XW'(sq_y));
            if (sqi_ff != w_s) begin
               sqi_in = sqi_ff + 1'b1;
            end else begin
               sqi_in = -w_s;
               if (sqj_ff != w_s) begin
                  sqj_in = sqj_ff + 1'b1;
               end else begin
                  sqj_in = -w_s;
                  if (!sq_sel_ff) begin
                     sq_sel_in = 1'b1;
                  end else begin
                     ls_in    = '0;
                     ldir_in  = '0;
                     state_in = ST_LSET;
                  end
               end
            end
         end
         ST_LSET: begin
            dcmd.go  = 1'b1;
            state_in = ST_LINE;
         end
         ST_LINE: begin
            we    = dstat.pt_valid && pt_on;
            waddr = cell_addr(XW'(dstat.px), XW'(dstat.py));
            if (dstat.done) begin
               if (ls_ff == '0) begin
                  if (w_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     ls_in    = WW'(1);
                     ldir_in  = '0;
                     state_in = ST_LSET;
                  end
               end else if (ldir_ff != 2'd3) begin
                  ldir_in  = ldir_ff + 1'b1;
                  state_in = ST_LSET;
               end else if (ls_ff == w_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ls_in    = ls_ff + 1'b1;
                  ldir_in  = '0;
                  state_in = ST_LSET;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign raddr = cell_addr(XW'(req_cell_x), XW'(req_cell_y));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      w_ff        <= w_in;
      clip_end_ff <= clip_end_in;
      found_ff    <= found_in;
      sqi_ff      <= sqi_in;
      sqj_ff      <= sqj_in;
      sq_sel_ff   <= sq_sel_in;
      ls_ff       <= ls_in;
      ldir_ff     <= ldir_in;
      rd_ok_ff    <= rd_ok_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_READ);
   assign rsp_road_bit = rd_ok_ff & ram_q;

endmodule

FILE: rtl/tlrp_ram.sv
module tlrp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: rtl/tlrp_div.sv
module tlrp_div import tlrp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [DIFF_W+FRAC_BITS-1:0]   num,
   input  logic [DIFF_W-1:0]             den,
   output logic                          done,
   output logic [DIFF_W+FRAC_BITS-1:0]   quo
);

   localparam int NUM_W = DIFF_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  qn_ff, qn_in;
   logic [DIFF_W-1:0] rem_ff, rem_in;
   logic [DIFF_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DIFF_W:0]   trial;

   always_comb begin
      qn_in   = qn_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, qn_ff[NUM_W-1]};
      if (go) begin
         qn_in  = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIFF_W'(trial - {1'b0, den_ff});
            qn_in  = {qn_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = DIFF_W'(trial);
            qn_in  = {qn_ff[NUM_W-2:0], 1'b0};
         end
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      qn_ff  <= qn_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = qn_ff;

endmodule

FILE: rtl/tlrp_dda.sv
module tlrp_dda import tlrp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  dda_cmd_type  cmd,
   output dda_stat_type stat
);

   localparam int NUM_W = DIFF_W + FRAC_BITS;
   localparam int CUR_W = COORD_W + 1 + FRAC_BITS;

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_DIVX = 2'd1;
   localparam logic [1:0] D_DIVY = 2'd2;
   localparam logic [1:0] D_RUN  = 2'd3;

   typedef logic signed [CUR_W-1:0] fix_type;

   logic [1:0]        state_ff, state_in;
   logic [DIFF_W-1:0] absdy_ff, absdy_in;
   logic              negx_ff, negx_in, negy_ff, negy_in;
   logic [DIFF_W-1:0] den_ff, den_in;
   logic [DIFF_W-1:0] rem_ff, rem_in;
   coord_type         ax_ff, ax_in, ay_ff, ay_in;
   fix_type           stepx_ff, stepx_in, stepy_ff, stepy_in;
   fix_type           curx_ff, curx_in, cury_ff, cury_in;

   logic signed [COORD_W:0] dx, dy;
   logic [DIFF_W-1:0] absdx_c, absdy_c, maxd_c, den_c;
   logic              div_go, div_done;
   logic [NUM_W-1:0]  div_num, div_quo;
   logic [DIFF_W-1:0] div_den;
   fix_type           step_c;

   function automatic coord_type to_cell(input fix_type c);
      fix_type m;
      m = (c < 0) ? -c : c;
      m = m >>> FRAC_BITS;
      return (c < 0) ? COORD_W'(-m) : COORD_W'(m);
   endfunction

   tlrp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      dx      = {cmd.bx[COORD_W-1], cmd.bx} - {cmd.ax[COORD_W-1], cmd.ax};
      dy      = {cmd.by[COORD_W-1], cmd.by} - {cmd.ay[COORD_W-1], cmd.ay};
      absdx_c = dx[COORD_W] ? DIFF_W'(-dx) : DIFF_W'(dx);
      absdy_c = dy[COORD_W] ? DIFF_W'(-dy) : DIFF_W'(dy);
      maxd_c  = (absdx_c > absdy_c) ? absdx_c : absdy_c;
      den_c   = (maxd_c == '0) ? DIFF_W'(1) : maxd_c;
      step_c  = fix_type'({1'b0, div_quo});

      state_in = state_ff;
      absdy_in = absdy_ff;
      negx_in  = negx_ff;
      negy_in  = negy_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      stepx_in = stepx_ff;
      stepy_in = stepy_ff;
      curx_in  = curx_ff;
      cury_in  = cury_ff;
      div_go   = 1'b0;
      div_num  = {absdy_ff, {FRAC_BITS{1'b0}}};
      div_den  = den_ff;

      unique case (state_ff)
         D_IDLE: begin
            if (cmd.go) begin
               div_go   = 1'b1;
               div_num  = {absdx_c, {FRAC_BITS{1'b0}}};
               div_den  = den_c;
               absdy_in = absdy_c;
               negx_in  = dx[COORD_W];
               negy_in  = dy[COORD_W];
               den_in   = den_c;
               rem_in   = maxd_c;
               ax_in    = cmd.ax;
               ay_in    = cmd.ay;
               state_in = D_DIVX;
            end
         end
         D_DIVX: begin
            if (div_done) begin
               stepx_in = negx_ff ? -step_c : step_c;
               div_go   = 1'b1;
               state_in = D_DIVY;
            end
         end
         D_DIVY: begin
            if (div_done) begin
               stepy_in = negy_ff ? -step_c : step_c;
               curx_in  = fix_type'(ax_ff) <<< FRAC_BITS;
               cury_in  = fix_type'(ay_ff) <<< FRAC_BITS;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (rem_ff == '0) begin
               state_in = D_IDLE;
            end else begin
               rem_in  = rem_ff - 1'b1;
               curx_in = curx_ff + stepx_ff;
               cury_in = cury_ff + stepy_ff;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      absdy_ff <= absdy_in;
      negx_ff  <= negx_in;
      negy_ff  <= negy_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      stepx_ff <= stepx_in;
      stepy_ff <= stepy_in;
      curx_ff  <= curx_in;
      cury_ff  <= cury_in;
   end

   assign stat.pt_valid = (state_ff == D_RUN);
   assign stat.done     = (state_ff == D_RUN) && (rem_ff == '0);
   assign stat.px       = to_cell(curx_ff);
   assign stat.py       = to_cell(cury_ff);

endmodule

FILE: rtl/tlrp_checker.sv
module tlrp_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_cmd,
   input logic rsp_valid
);

   a_read_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd) |=> rsp_valid)
      else $error("read transfer without response");

   a_draw_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_cmd) |=> !rsp_valid)
      else $error("draw transfer produced a response");

   a_resp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_cmd))
      else $error("response without read transfer");

   a_clear_busy: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("not busy during clear pass");

endmodule

bind thick_line_road_plotter_unit tlrp_checker u_tlrp_checker (.*);

FILE: tb/tb_top.sv
module tb_top;
   import tlrp_pkg::*;

   localparam int GRID       = 256;
   localparam int FRAC       = 16;
   localparam int HW_MAX     = 15;
   localparam int STALL_MAX  = 300000;
   localparam bit CMD_DRAW   = 1'b0;
   localparam bit CMD_READ   = 1'b1;

   typedef struct {
      bit cmd;
      logic signed [10:0] sx, sy, ex, ey;
      logic [3:0] hw;
      logic [7:0] cx, cy;
      int idle_pct;
      bit drain;
   } road_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = 1'b0;
   logic signed [10:0] req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic [3:0] req_half_width = '0;
   logic [7:0] req_cell_x = '0, req_cell_y = '0;
   logic rsp_valid, rsp_road_bit;

   road_cmd_type pending_cmds[$];
   bit expected_bits[$];
   bit road_map [0:GRID*GRID-1];
   int fail_count = 0;
   int quiet_cycles = 0;
   int cur_idle = 0;
   bit cur_drain = 0;

   thick_line_road_plotter_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_half_width(req_half_width),
      .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .rsp_valid(rsp_valid), .rsp_road_bit(rsp_road_bit)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit on_grid(int x, int y);
      return x >= 0 && x < GRID && y >= 0 && y < GRID;
   endfunction

   function automatic int dda_point(int a, int b, int n, int i);
      longint den, d, mag, step, cur;
      den = (n - 1 > 1) ? longint'(n - 1) : 64'sd1;
      d = longint'(b) - longint'(a);
      mag = ((d < 0) ? -d : d) * (64'sd1 <<< FRAC) / den;
      step = (d < 0) ? -mag : mag;
      cur = longint'(a) * (64'sd1 <<< FRAC) + longint'(i) * step;
      if (cur < 0) return -int'((-cur) >>> FRAC);
      return int'(cur >>> FRAC);
   endfunction

   function automatic int point_count(int ax, int ay, int bx, int by);
      int dx, dy;
      dx = (bx > ax) ? bx - ax : ax - bx;
      dy = (by > ay) ? by - ay : ay - by;
      return ((dx > dy) ? dx : dy) + 1;
   endfunction

   function automatic void mark(int x, int y);
      if (on_grid(x, y)) road_map[x*GRID + y] = 1'b1;
   endfunction

   function automatic void trace_line(int ax, int ay, int bx, int by);
      int n;
      n = point_count(ax, ay, bx, by);
      for (int i = 0; i < n; i++) mark(dda_point(ax, bx, n, i), dda_point(ay, by, n, i));
   endfunction

   function automatic void fill_square(int cx, int cy, int w);
      for (int j = -w; j <= w; j++)
         for (int i = -w; i <= w; i++) mark(cx + i, cy + j);
   endfunction

   function automatic void offset_line(int sx, int sy, int ex, int ey, int ox, int oy);
      int psx, psy, pex, pey;
      psx = sx + ox; psy = sy + oy; pex = ex + ox; pey = ey + oy;
      if (!on_grid(psx, psy)) begin psx = sx; psy = sy; end
      if (!on_grid(pex, pey)) begin pex = ex; pey = ey; end
      trace_line(psx, psy, pex, pey);
   endfunction

   function automatic void plot_road(int sx, int sy, int ex, int ey, int w);
      int n, px, py;
      n = point_count(sx, sy, ex, ey);
      if (w > HW_MAX) w = HW_MAX;
      if (!on_grid(sx, sy)) begin
         for (int i = 0; i < n; i++) begin
            px = dda_point(sx, ex, n, i); py = dda_point(sy, ey, n, i);
            if (on_grid(px, py)) begin sx = px; sy = py; break; end
         end
      end else if (!on_grid(ex, ey)) begin
         for (int i = n - 1; i >= 0; i--) begin
            px = dda_point(sx, ex, n, i); py = dda_point(sy, ey, n, i);
            if (on_grid(px, py)) begin ex = px; ey = py; break; end
         end
      end
      if (!on_grid(sx, sy) || !on_grid(ex, ey)) return;
      fill_square(sx, sy, w);
      fill_square(ex, ey, w);
      trace_line(sx, sy, ex, ey);
      for (int s = 1; s <= w; s++) begin
         offset_line(sx, sy, ex, ey, -s, 0);
         offset_line(sx, sy, ex, ey, 0, -s);
         offset_line(sx, sy, ex, ey, s, 0);
         offset_line(sx, sy, ex, ey, 0, s);
      end
   endfunction

   function automatic void apply_cmd(road_cmd_type c);
      if (c.cmd == CMD_DRAW)
         plot_road(int'(c.sx), int'(c.sy), int'(c.ex), int'(c.ey), int'(c.hw));
      else
         expected_bits.insert(expected_bits.size(),
                              road_map[int'(c.cx)*GRID + int'(c.cy)]);
   endfunction

   function automatic road_cmd_type noise_cmd();
      road_cmd_type c;
      c.cmd = CMD_DRAW;
      c.sx = 11'($urandom); c.sy = 11'($urandom);
      c.ex = 11'($urandom); c.ey = 11'($urandom);
      c.hw = 4'($urandom); c.cx = 8'($urandom); c.cy = 8'($urandom);
      c.idle_pct = 0; c.drain = 0;
      return c;
   endfunction

   function automatic void add_draw(int sx, int sy, int ex, int ey, int w);
      road_cmd_type c;
      c = noise_cmd();
      c.sx = 11'(sx); c.sy = 11'(sy); c.ex = 11'(ex); c.ey = 11'(ey); c.hw = 4'(w);
      pending_cmds.insert(pending_cmds.size(), c);
   endfunction

   function automatic void add_read(int x, int y);
      road_cmd_type c;
      c = noise_cmd();
      c.cmd = CMD_READ; c.cx = 8'(x); c.cy = 8'(y);
      pending_cmds.insert(pending_cmds.size(), c);
   endfunction

   function automatic int near(int v);
      int r;
      r = v + int'($urandom_range(0, 10)) - 5;
      return (r < 0) ? 0 : (r > GRID - 1) ? GRID - 1 : r;
   endfunction

   function automatic int map_coord();
      if ($urandom_range(0, 99) < 75) return $urandom_range(0, GRID - 1);
      return int'($urandom_range(0, 2047)) - 1024;
   endfunction

   function automatic int pick_width();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, 3);
      if (r < 96) return $urandom_range(4, 8);
      return $urandom_range(9, 15);
   endfunction

   // driver
   always @(posedge clock) begin
      road_cmd_type c;
      bit take;
      if (reset) begin
         start <= 1'b0;
      end else begin
         take = !start || !busy;
         if (start && !busy) apply_cmd('{req_cmd, req_start_x, req_start_y, req_end_x,
            req_end_y, req_half_width, req_cell_x, req_cell_y, cur_idle, cur_drain});
         if (take) begin
            if (pending_cmds.size() == 0 ||
                (pending_cmds[0].drain && expected_bits.size() != 0) ||
                ($urandom_range(0, 99) < pending_cmds[0].idle_pct)) begin
               start <= 1'b0;
            end else begin
               c = pending_cmds.pop_front();
               req_cmd <= c.cmd;
               req_start_x <= c.sx; req_start_y <= c.sy;
               req_end_x <= c.ex; req_end_y <= c.ey;
               req_half_width <= c.hw;
               req_cell_x <= c.cx; req_cell_y <= c.cy;
               cur_idle <= c.idle_pct; cur_drain <= c.drain;
               start <= 1'b1;
            end
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      bit want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_bits.size() == 0) begin
               $error("road_bit: unexpected transfer, actual %0b", rsp_road_bit);
               fail_count++;
            end else begin
               want = expected_bits.pop_front();
               if (rsp_road_bit !== want) begin
                  $error("road_bit: expected %0b actual %0b", want, rsp_road_bit);
                  fail_count++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > STALL_MAX) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int lx, ly, total, n;
      for (int i = 0; i < GRID*GRID; i++) road_map[i] = 1'b0;

      // directed
      add_read(0, 0);
      add_read(255, 255);
      add_draw(0, 0, 255, 255, 0);
      add_read(0, 0); add_read(255, 255); add_read(128, 128); add_read(128, 129);
      add_draw(-1024, -1024, 100, 50, 2);
      add_read(100, 50); add_read(0, 0); add_read(102, 52);
      add_draw(10, 200, 1023, 500, 1);
      add_read(10, 200); add_read(255, 225);
      add_draw(-1024, 1023, -5, -1024, 3);
      add_draw(1023, -1024, 1023, 1023, 0);
      add_draw(0, 255, 0, 255, 15);
      add_read(15, 240); add_read(16, 240); add_read(0, 255);
      add_draw(128, 20, 131, 230, 4);
      add_read(124, 100); add_read(135, 100); add_read(136, 100);
      add_draw(255, 0, 0, 3, 1);
      add_read(128, 1); add_read(7, 3);

      // random
      lx = 128; ly = 128;
      for (int k = 0; k < 120; k++) begin
         if ($urandom_range(0, 99) < 32) begin
            lx = map_coord(); ly = map_coord();
            add_draw(lx, ly, map_coord(), map_coord(), pick_width());
            if (lx < 0 || lx > 255) lx = pending_cmds[$].ex;
            if (ly < 0 || ly > 255) ly = pending_cmds[$].ey;
         end else if ($urandom_range(0, 99) < 70) begin
            add_read(near(lx), near(ly));
         end else begin
            add_read($urandom_range(0, 255), $urandom_range(0, 255));
         end
      end

      total = pending_cmds.size();
      for (int i = 0; i < total; i++) begin
         n = i * 3 / total;
         pending_cmds[i].idle_pct = (n == 0) ? 15 : (n == 1) ? 82 : 0;
         pending_cmds[i].drain = (i % 40 == 39);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_cmds.size() != 0 || start || expected_bits.size() != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
